[rtl/rls_pkg.sv]
`timescale 1ns / 1ps
package rls_pkg;

	// Stack geometry
	localparam int MAX_DEPTH = 8;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	// Field widths
	localparam int CMD_W  = 2;
	localparam int POS_W  = 32;
	localparam int PASS_W = 31;
	localparam int CNT_W  = 32;
	localparam int NEST_W = 4;

	// Counter code for a loop that never ends on its own
	localparam logic [CNT_W-1:0] INFINITE_COUNT = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET    = 2'd0,
		CMD_LOOP   = 2'd1,
		CMD_CANCEL = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [POS_W-1:0]  position;
		logic [PASS_W-1:0] pass_count;
	} rls_item_t;

	typedef struct packed {
		logic              seek;
		logic [POS_W-1:0]  seek_position;
		logic              dropped;
		logic [NEST_W-1:0] nesting_depth;
		logic              any_active;
	} rls_result_t;

	// Fold the stack depth into the reported depth field (wraps above 15)
	function automatic logic [NEST_W-1:0] to_nest(input logic [DEPTH_W-1:0] d);
		logic [NEST_W+DEPTH_W-1:0] wide;
		wide = {{NEST_W{1'b0}}, d};
		return wide[NEST_W-1:0];
	endfunction

endpackage

[rtl/rls_stack.sv]
`timescale 1ns / 1ps
module rls_stack import rls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  rls_item_t   item,
	output rls_result_t result_d
);

	logic [POS_W-1:0]   pos_q [MAX_DEPTH];
	logic [CNT_W-1:0]   cnt_q [MAX_DEPTH];
	logic               nz_q  [MAX_DEPTH];
	logic [DEPTH_W-1:0] depth_q;

	logic [DEPTH_W-1:0] depth_n;
	logic               nz_n [MAX_DEPTH];
	logic               full;
	logic               empty;
	logic [IDX_W-1:0]   top_idx;
	logic [IDX_W-1:0]   push_idx;
	logic [CNT_W-1:0]   top_cnt;
	logic [CNT_W-1:0]   new_cnt;
	logic               push_en;
	logic               dec_en;
	logic               cancel_en;
	logic               seek;
	logic               dropped;
	logic [DEPTH_W-1:0] top_full;

	// Decode stack position
	assign full     = (depth_q == DEPTH_W'(MAX_DEPTH));
	assign empty    = (depth_q == '0);
	assign top_full = depth_q - DEPTH_W'(1);
	assign top_idx  = top_full[IDX_W-1:0];
	assign push_idx = depth_q[IDX_W-1:0];
	assign top_cnt  = cnt_q[top_idx];
	assign new_cnt  = (item.pass_count == '0) ? INFINITE_COUNT
		: {1'b0, item.pass_count - PASS_W'(1)};

	// Decide the command's effect
	always_comb begin
		depth_n   = depth_q;
		push_en   = 1'b0;
		dec_en    = 1'b0;
		cancel_en = 1'b0;
		seek      = 1'b0;
		dropped   = 1'b0;
		case (item.cmd)
			CMD_SET: begin
				if (full) begin
					dropped = 1'b1;
				end else begin
					push_en = 1'b1;
					depth_n = depth_q + DEPTH_W'(1);
				end
			end
			CMD_LOOP: begin
				if (!empty) begin
					if (top_cnt == '0) begin
						depth_n = top_full;
					end else begin
						seek   = 1'b1;
						dec_en = !top_cnt[CNT_W-1];
					end
				end
			end
			CMD_CANCEL: begin
				cancel_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Next activity flags, then fold the live ones
	always_comb begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			nz_n[i] = nz_q[i];
			if (cancel_en) begin
				nz_n[i] = 1'b0;
			end else if (push_en && push_idx == IDX_W'(i)) begin
				nz_n[i] = (new_cnt != '0);
			end else if (dec_en && top_idx == IDX_W'(i)) begin
				nz_n[i] = (top_cnt != CNT_W'(1));
			end
		end
	end

	always_comb begin
		result_d               = '0;
		result_d.seek          = seek;
		result_d.seek_position = seek ? pos_q[top_idx] : '0;
		result_d.dropped       = dropped;
		result_d.nesting_depth = to_nest(depth_n);
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (DEPTH_W'(i) < depth_n && nz_n[i]) begin
				result_d.any_active = 1'b1;
			end
		end
	end

	// Advance depth on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (fire) begin
			depth_q <= depth_n;
		end
	end

	// Update stack entries
	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < MAX_DEPTH; i++) begin
				nz_q[i] <= nz_n[i];
				if (cancel_en) begin
					cnt_q[i] <= '0;
				end else if (push_en && push_idx == IDX_W'(i)) begin
					cnt_q[i] <= new_cnt;
					pos_q[i] <= item.position;
				end else if (dec_en && top_idx == IDX_W'(i)) begin
					cnt_q[i] <= top_cnt - CNT_W'(1);
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_DEPTH))
		else $error("stack depth above limit");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(depth_q))
		else $error("depth moved without a beat");

	a_drop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.cmd == CMD_SET && full |=> $stable(depth_q))
		else $error("push on full stack changed depth");

	a_loop_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.cmd == CMD_LOOP
		|=> depth_q == $past(depth_q) || depth_q == DEPTH_W'($past(depth_q) - DEPTH_W'(1)))
		else $error("loop point moved depth by more than one");
`endif

endmodule

[rtl/rls_out_reg.sv]
`timescale 1ns / 1ps
module rls_out_reg import rls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  rls_result_t result_d,
	output logic        result_valid,
	input  logic        result_stall,
	output rls_result_t result
);

	logic        valid_q;
	rls_result_t data_q;

	// Hold the beat until taken; load a new one on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_q <= result_d;
		end
	end

	assign result_valid = valid_q;
	assign result       = data_q;

endmodule

[rtl/repeat_loop_stack_core.sv]
`timescale 1ns / 1ps
// Nested repeat-loop stack.
// Input channel item_valid / item_stall / item carries one command beat:
// set marker (push position and pass count), loop point (seek back or pop
// the top marker) or cancel all (zero every stacked counter).
// Output channel result_valid / result_stall / result returns one beat per
// command: seek request and position, drop flag for a push on a full stack,
// nesting depth and whether any stacked counter is still non-zero.
// The result is registered and appears in the cycle after the command is accepted.
// Throughput: one command per cycle while item_stall is low; the whole update reads
// only the top entry and the per-entry activity flags, so it is one combinational step.
// A held result stalls the input: item_stall is high while result_valid is
// high and result_stall is high; the held beat stays unchanged.
// Reset empties the stack and clears any pending result; marker contents
// are not cleared, only entries below the depth are ever read.
module repeat_loop_stack_core import rls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  rls_item_t   item,
	output logic        result_valid,
	input  logic        result_stall,
	output rls_result_t result
);

	logic        fire;
	rls_result_t result_d;

	// Accept while the result register is free or draining
	assign item_stall = result_valid && result_stall;
	assign fire       = item_valid && !item_stall;

	rls_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item),
		.result_d (result_d)
	);

	rls_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.result_d     (result_d),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[bench/loop_stack_checker.sv]
`timescale 1ns / 1ps
module loop_stack_checker import rls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  rls_item_t   item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  rls_result_t result,
	output int          pending,
	output int          failures
);

	// Shadow copy of the marker stack
	logic [POS_W-1:0] shadow_pos [MAX_DEPTH];
	logic [CNT_W-1:0] shadow_cnt [MAX_DEPTH];
	int               shadow_depth;

	rls_result_t expected_q [$];
	int          mismatch_count;

	// Apply one command beat to the shadow stack and return the beat it must produce
	function automatic rls_result_t step_loop_stack(input rls_item_t beat);
		rls_result_t r;
		int          top;
		r = '0;
		case (beat.cmd)
			CMD_SET: begin
				if (shadow_depth >= MAX_DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					shadow_pos[shadow_depth] = beat.position;
					shadow_cnt[shadow_depth] = (beat.pass_count == '0) ? INFINITE_COUNT
						: {1'b0, beat.pass_count} - 1;
					shadow_depth++;
				end
			end
			CMD_LOOP: begin
				if (shadow_depth > 0) begin
					top = shadow_depth - 1;
					if (shadow_cnt[top] == '0) begin
						shadow_depth--;
					end else begin
						r.seek          = 1'b1;
						r.seek_position = shadow_pos[top];
						// infinite marker keeps its code
						if (!shadow_cnt[top][CNT_W-1])
							shadow_cnt[top] = shadow_cnt[top] - 1;
					end
				end
			end
			CMD_CANCEL: begin
				for (int i = 0; i < shadow_depth; i++)
					shadow_cnt[i] = '0;
			end
			default: ;
		endcase
		r.nesting_depth = shadow_depth[NEST_W-1:0];
		for (int i = 0; i < shadow_depth; i++)
			if (shadow_cnt[i] != '0)
				r.any_active = 1'b1;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Compare result beats, then record the expectation of each accepted command beat
	always @(posedge clk or negedge arst_n) begin
		rls_result_t exp_r;
		if (!arst_n) begin
			shadow_depth   = 0;
			expected_q.delete();
			mismatch_count = 0;
			pending  <= 0;
			failures <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, result);
					mismatch_count++;
				end else begin
					exp_r = expected_q.pop_front();
					check_field("seek", exp_r.seek, result.seek);
					check_field("seek_position", exp_r.seek_position, result.seek_position);
					check_field("dropped", exp_r.dropped, result.dropped);
					check_field("nesting_depth", exp_r.nesting_depth, result.nesting_depth);
					check_field("any_active", exp_r.any_active, result.any_active);
				end
			end
			if (item_valid && !item_stall)
				expected_q.push_back(step_loop_stack(item));
			pending  <= expected_q.size();
			failures <= mismatch_count;
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import rls_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_BEATS = 600;
	localparam int CYCLE_LIMIT  = 300000;
	localparam logic [PASS_W-1:0] PASS_MAX = '1;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	rls_item_t   item;
	logic        result_valid;
	logic        result_stall;
	rls_result_t result;
	int          pending;
	int          failures;

	int burst_left;
	int beats_sent;
	int cycle_count = 0;
	int stall_mode  = 0;
	int stall_left  = 0;

	repeat_loop_stack_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	loop_stack_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.pending      (pending),
		.failures     (failures)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Stall the result side in stretches: none, light, heavy
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(10, 60);
			end
			stall_left--;
			case (stall_mode)
				0:       result_stall <= 1'b0;
				1:       result_stall <= ($urandom_range(0, 2) == 0);
				default: result_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	function automatic rls_item_t make_beat(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input logic [PASS_W-1:0] pass);
		rls_item_t b;
		b.cmd        = cmd;
		b.position   = pos;
		b.pass_count = pass;
		return b;
	endfunction

	function automatic logic [POS_W-1:0] rand_pos();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly short loops, some infinite, some huge
	function automatic logic [PASS_W-1:0] rand_pass();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return PASS_MAX;
			2:       return PASS_W'($urandom);
			default: return PASS_W'($urandom_range(1, 4));
		endcase
	endfunction

	// Drive one command beat, opening a new burst after a random gap when due
	task automatic send_beat(input rls_item_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item       <= b;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	initial begin
		int n;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		burst_left   = 0;
		beats_sent   = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Infinite marker: seek without decrement, cancel, then pop
		send_beat(make_beat(CMD_SET, '0, '0));
		send_beat(make_beat(CMD_LOOP, '1, PASS_MAX));
		send_beat(make_beat(CMD_CANCEL, '0, '0));
		send_beat(make_beat(CMD_LOOP, '0, '0));
		// Loop on an empty stack, unused selector
		send_beat(make_beat(CMD_LOOP, '1, '1));
		send_beat(make_beat(CMD_UNUSED, '1, '1));
		// Fill the stack with extreme entries, then overflow it
		send_beat(make_beat(CMD_SET, '1, PASS_MAX));
		send_beat(make_beat(CMD_SET, 32'h8000_0001, 31'd1));
		send_beat(make_beat(CMD_SET, 32'h5555_5555, 31'd2));
		send_beat(make_beat(CMD_SET, 32'hAAAA_AAAA, '0));
		send_beat(make_beat(CMD_SET, '0, 31'd1));
		send_beat(make_beat(CMD_SET, 32'h0000_0001, 31'h4000_0000));
		send_beat(make_beat(CMD_SET, 32'h7FFF_FFFF, 31'd3));
		send_beat(make_beat(CMD_SET, 32'hFFFF_FFFE, 31'd1));
		send_beat(make_beat(CMD_SET, '1, '1));
		send_beat(make_beat(CMD_UNUSED, '0, '0));
		send_beat(make_beat(CMD_CANCEL, '1, '1));
		// Drain: every entry pops at its next loop point
		repeat (8)
			send_beat(make_beat(CMD_LOOP, rand_pos(), rand_pass()));

		// Random part: nests of pushes followed by loop points, plus noise
		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			if ($urandom_range(0, 99) < 70) begin
				n = $urandom_range(1, 9);
				repeat (n)
					send_beat(make_beat(CMD_SET, rand_pos(),
						($urandom_range(0, 7) == 0) ? rand_pass()
						: PASS_W'($urandom_range(1, 3))));
				repeat ($urandom_range(n, 4 * n)) begin
					if ($urandom_range(0, 19) == 0)
						send_beat(make_beat(CMD_CANCEL, $urandom, PASS_W'($urandom)));
					else
						send_beat(make_beat(CMD_LOOP, $urandom, PASS_W'($urandom)));
				end
			end else begin
				send_beat(make_beat(CMD_W'($urandom_range(0, 3)), $urandom,
					PASS_W'($urandom)));
			end
		end
		item_valid <= 1'b0;
		// Let the count see the last accepted beat
		@(posedge clk);

		// Drain outstanding results, then watch a little longer for strays
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[filelist.f]
rtl/rls_pkg.sv
rtl/rls_stack.sv
rtl/rls_out_reg.sv
rtl/repeat_loop_stack_core.sv
bench/loop_stack_checker.sv
bench/testbench.sv
